[design/ec2d_pkg.sv]
// ----------------------------------------------------------------------------
// Elastic collision package
// Shared constants, status codes, divider step and pipeline side-band types.
// ----------------------------------------------------------------------------
package ec2d_pkg;

	localparam int DIV_STEPS = 34;
	localparam int DEN_W     = 29;
	localparam int DIR_MSB   = 13;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_COINCIDENT = 2'd1;
	localparam logic [1:0] ST_ZERO_MASS  = 2'd2;
	localparam logic [1:0] ST_SAT        = 2'd3;

	typedef struct packed {
		logic [DEN_W-1:0]     rem;
		logic [DIV_STEPS-1:0] nq;
	} div_state_t;

	typedef struct packed {
		logic signed [31:0] vax;
		logic signed [31:0] vay;
		logic signed [31:0] vbx;
		logic signed [31:0] vby;
		logic [1:0]         stat;
		logic [23:0]        ma_m;
		logic [23:0]        mb_m;
		logic [24:0]        ms_m;
		logic               sma;
		logic               smb;
		logic               sms;
		logic               sqx;
		logic               sqy;
		logic [3:0]         neg;
		logic [3:0]         ovf;
	} side_t;

	function automatic div_state_t div_step(input div_state_t cur,
			input logic [DEN_W-1:0] den);
		logic [DEN_W:0] t;
		logic           hit;
		div_state_t     nxt;
		t   = {cur.rem, cur.nq[DIV_STEPS-1]};
		hit = (t >= {1'b0, den});
		if (hit) begin
			t = t - {1'b0, den};
		end
		nxt.rem = t[DEN_W-1:0];
		nxt.nq  = {cur.nq[DIV_STEPS-2:0], hit};
		return nxt;
	endfunction

endpackage

[design/ec2d_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned division, one quotient bit per register stage, stalls with en.
// ----------------------------------------------------------------------------
module ec2d_div import ec2d_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  div_state_t           start,
	input  logic [DEN_W-1:0]     den,
	output logic [DIV_STEPS-1:0] quo
);

	div_state_t       step_s [DIV_STEPS];
	logic [DEN_W-1:0] den_s  [DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			step_s[0] <= div_step(start, den);
			den_s[0]  <= den;
			for (int k = 1; k < DIV_STEPS; k++) begin
				step_s[k] <= div_step(step_s[k-1], den_s[k-1]);
				den_s[k]  <= den_s[k-1];
			end
		end
	end

	assign quo = step_s[DIV_STEPS-1].nq;

endmodule

[design/elastic_collision_2d_top.sv]
// ----------------------------------------------------------------------------
// Two-dimensional elastic collision
// Computes post-collision velocities of two bodies in signed Q16.16.
// ----------------------------------------------------------------------------
// The pair channel takes one beat with both centres, both velocities and
// both masses; the result channel returns one beat with the four new
// velocity components and a status code.
// The unit is a 76-stage pipeline. One pair is accepted every cycle
// while the result side does not stall. The depth is set by two banks
// of pipelined restoring dividers of 34 stages each, one for the
// projection onto the line of centres and one for the division by the
// mass sum.
// All stages advance together. When a result is valid and not taken, the
// whole pipeline holds and pair_ready is low; nothing is lost or repeated.
// Coincident centres and a zero mass sum return the input velocities with
// status 1 or 2; a clamped velocity gives status 3.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module elastic_collision_2d_top import ec2d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pair_valid,
	output logic               pair_ready,
	input  logic signed [31:0] pos_a_x,
	input  logic signed [31:0] pos_a_y,
	input  logic signed [31:0] pos_b_x,
	input  logic signed [31:0] pos_b_y,
	input  logic signed [31:0] vel_a_x,
	input  logic signed [31:0] vel_a_y,
	input  logic signed [31:0] vel_b_x,
	input  logic signed [31:0] vel_b_y,
	input  logic signed [23:0] mass_a,
	input  logic signed [23:0] mass_b,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] new_vel_a_x,
	output logic signed [31:0] new_vel_a_y,
	output logic signed [31:0] new_vel_b_x,
	output logic signed [31:0] new_vel_b_y,
	output logic [1:0]         status
);

	logic adv;
	logic out_vld_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vd1_s [DIV_STEPS];
	logic vd2_s [DIV_STEPS];

	logic signed [32:0] dx_c, dy_c, dvx_c, dvy_c;
	logic signed [24:0] msum_c;
	side_t              side_c;

	logic [32:0]        mx_s1, my_s1;
	logic               sdx_s1, sdy_s1;
	logic signed [32:0] dvx_s1, dvy_s1;
	side_t              side_s1;

	logic [32:0]        big_c;
	logic [5:0]         p_c;
	logic [32:0]        mx_s2, my_s2;
	logic [5:0]         p_s2;
	logic               sdx_s2, sdy_s2;
	logic signed [32:0] dvx_s2, dvy_s2;
	side_t              side_s2;

	logic [5:0]         sh_c;
	logic [13:0]        exm_c, eym_c;
	logic signed [14:0] ex_c, ey_c;
	logic [13:0]        exm_s3, eym_s3;
	logic signed [14:0] ex_s3, ey_s3;
	logic               sdx_s3, sdy_s3;
	logic signed [32:0] dvx_s3, dvy_s3;
	side_t              side_s3;

	logic signed [47:0] px_s4, py_s4;
	logic [27:0]        lx_s4, ly_s4;
	logic [13:0]        exm_s4, eym_s4;
	logic               sdx_s4, sdy_s4;
	side_t              side_s4;

	logic signed [48:0] dot_s5;
	logic [DEN_W-1:0]   len2_s5;
	logic [13:0]        exm_s5, eym_s5;
	logic               sdx_s5, sdy_s5;
	side_t              side_s5;

	logic [48:0]        dotm_c;
	side_t              side6_c;
	logic [62:0]        nx_s6, ny_s6;
	logic [DEN_W-1:0]   len2_s6;
	side_t              side_s6;

	div_state_t         dstart_x, dstart_y;
	logic [DIV_STEPS-1:0] qxm, qym;
	side_t              sd1_s [DIV_STEPS];

	side_t              side7n_c;
	logic [58:0]        n_s7 [4];
	side_t              side_s7;
	side_t              side7_c;
	div_state_t         dstart2 [4];
	logic [DEN_W-1:0]   den2_c;
	logic [DIV_STEPS-1:0] q2 [4];
	side_t              sd2_s [DIV_STEPS];

	logic signed [31:0] vin_c [4];
	logic signed [31:0] vout_c [4];
	logic [3:0]         sat_c;
	logic signed [31:0] vout_q [4];
	logic [1:0]         stat_q;

	function automatic logic signed [31:0] clamp36(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign adv        = !out_vld_q || result_ready;
	assign pair_ready = adv;

	// Stage 1: differences, magnitudes and special cases.
	always_comb begin
		dx_c   = {pos_a_x[31], pos_a_x} - {pos_b_x[31], pos_b_x};
		dy_c   = {pos_a_y[31], pos_a_y} - {pos_b_y[31], pos_b_y};
		dvx_c  = {vel_b_x[31], vel_b_x} - {vel_a_x[31], vel_a_x};
		dvy_c  = {vel_b_y[31], vel_b_y} - {vel_a_y[31], vel_a_y};
		msum_c = {mass_a[23], mass_a} + {mass_b[23], mass_b};
		side_c      = '0;
		side_c.vax  = vel_a_x;
		side_c.vay  = vel_a_y;
		side_c.vbx  = vel_b_x;
		side_c.vby  = vel_b_y;
		side_c.sma  = mass_a[23];
		side_c.smb  = mass_b[23];
		side_c.sms  = msum_c[24];
		side_c.ma_m = mass_a[23] ? 24'(-mass_a) : 24'(mass_a);
		side_c.mb_m = mass_b[23] ? 24'(-mass_b) : 24'(mass_b);
		side_c.ms_m = msum_c[24] ? 25'(-msum_c) : 25'(msum_c);
		if (dx_c == '0 && dy_c == '0) begin
			side_c.stat = ST_COINCIDENT;
		end else if (msum_c == '0) begin
			side_c.stat = ST_ZERO_MASS;
		end else begin
			side_c.stat = ST_OK;
		end
	end

	// Stage 2: leading one of the larger offset magnitude.
	always_comb begin
		big_c = (mx_s1 > my_s1) ? mx_s1 : my_s1;
		p_c   = '0;
		for (int i = 0; i < 33; i++) begin
			if (big_c[i]) begin
				p_c = 6'(i);
			end
		end
	end

	// Stage 3: normalize the direction to a 14-bit magnitude.
	always_comb begin
		if (p_s2 >= 6'(DIR_MSB)) begin
			sh_c  = 6'(p_s2 - 6'(DIR_MSB));
			exm_c = 14'(mx_s2 >> sh_c);
			eym_c = 14'(my_s2 >> sh_c);
		end else begin
			sh_c  = 6'(6'(DIR_MSB) - p_s2);
			exm_c = 14'(mx_s2 << sh_c);
			eym_c = 14'(my_s2 << sh_c);
		end
		ex_c = {1'b0, exm_c};
		ey_c = {1'b0, eym_c};
		if (sdx_s2) begin
			ex_c = -ex_c;
		end
		if (sdy_s2) begin
			ey_c = -ey_c;
		end
	end

	assign dotm_c = dot_s5[48] ? 49'(-dot_s5) : 49'(dot_s5);

	always_comb begin
		side6_c     = side_s5;
		side6_c.sqx = dot_s5[48] ^ sdx_s5;
		side6_c.sqy = dot_s5[48] ^ sdy_s5;
	end

	assign dstart_x.rem = nx_s6[62:34];
	assign dstart_x.nq  = nx_s6[33:0];
	assign dstart_y.rem = ny_s6[62:34];
	assign dstart_y.nq  = ny_s6[33:0];

	ec2d_div u_div_x (
		.clk   (clk),
		.en    (adv),
		.start (dstart_x),
		.den   (len2_s6),
		.quo   (qxm)
	);

	ec2d_div u_div_y (
		.clk   (clk),
		.en    (adv),
		.start (dstart_y),
		.den   (len2_s6),
		.quo   (qym)
	);

	always_comb begin
		side7n_c     = sd1_s[DIV_STEPS-1];
		side7n_c.neg = {
			~side7n_c.sqy ^ side7n_c.sma ^ side7n_c.sms,
			~side7n_c.sqx ^ side7n_c.sma ^ side7n_c.sms,
			side7n_c.sqy ^ side7n_c.smb ^ side7n_c.sms,
			side7n_c.sqx ^ side7n_c.smb ^ side7n_c.sms
		};
	end

	// Second division by the mass sum, with an early quotient overflow check.
	assign den2_c = DEN_W'(side_s7.ms_m);

	always_comb begin
		side7_c = side_s7;
		for (int i = 0; i < 4; i++) begin
			dstart2[i].rem = DEN_W'(n_s7[i][58:34]);
			dstart2[i].nq  = n_s7[i][33:0];
			side7_c.ovf[i] = (n_s7[i][58:34] >= side_s7.ms_m);
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_div_m
		ec2d_div u_div_m (
			.clk   (clk),
			.en    (adv),
			.start (dstart2[g]),
			.den   (den2_c),
			.quo   (q2[g])
		);
	end

	// Final stage: apply signs, add to the old velocity and clamp.
	always_comb begin
		logic signed [35:0] qs;
		logic signed [35:0] sum;
		vin_c[0] = sd2_s[DIV_STEPS-1].vax;
		vin_c[1] = sd2_s[DIV_STEPS-1].vay;
		vin_c[2] = sd2_s[DIV_STEPS-1].vbx;
		vin_c[3] = sd2_s[DIV_STEPS-1].vby;
		for (int i = 0; i < 4; i++) begin
			qs = {2'b00, q2[i]};
			if (sd2_s[DIV_STEPS-1].neg[i]) begin
				qs = -qs;
			end
			sum = 36'(vin_c[i]) + qs;
			if (sd2_s[DIV_STEPS-1].ovf[i]) begin
				vout_c[i] = sd2_s[DIV_STEPS-1].neg[i] ? 32'sh80000000 : 32'sh7FFFFFFF;
				sat_c[i]  = 1'b1;
			end else begin
				vout_c[i] = clamp36(sum);
				sat_c[i]  = (sum > 36'sd2147483647) || (sum < -36'sd2147483648);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			out_vld_q <= 1'b0;
			for (int k = 0; k < DIV_STEPS; k++) begin
				vd1_s[k] <= 1'b0;
				vd2_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s1   <= pair_valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_s5   <= vld_s4;
			vld_s6   <= vld_s5;
			vd1_s[0] <= vld_s6;
			vd2_s[0] <= vld_s7;
			for (int k = 1; k < DIV_STEPS; k++) begin
				vd1_s[k] <= vd1_s[k-1];
				vd2_s[k] <= vd2_s[k-1];
			end
			vld_s7    <= vd1_s[DIV_STEPS-1];
			out_vld_q <= vd2_s[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1   <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
			my_s1   <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
			sdx_s1  <= dx_c[32];
			sdy_s1  <= dy_c[32];
			dvx_s1  <= dvx_c;
			dvy_s1  <= dvy_c;
			side_s1 <= side_c;

			mx_s2   <= mx_s1;
			my_s2   <= my_s1;
			p_s2    <= p_c;
			sdx_s2  <= sdx_s1;
			sdy_s2  <= sdy_s1;
			dvx_s2  <= dvx_s1;
			dvy_s2  <= dvy_s1;
			side_s2 <= side_s1;

			exm_s3  <= exm_c;
			eym_s3  <= eym_c;
			ex_s3   <= ex_c;
			ey_s3   <= ey_c;
			sdx_s3  <= sdx_s2;
			sdy_s3  <= sdy_s2;
			dvx_s3  <= dvx_s2;
			dvy_s3  <= dvy_s2;
			side_s3 <= side_s2;

			px_s4   <= 48'(dvx_s3) * 48'(ex_s3);
			py_s4   <= 48'(dvy_s3) * 48'(ey_s3);
			lx_s4   <= 28'(exm_s3) * 28'(exm_s3);
			ly_s4   <= 28'(eym_s3) * 28'(eym_s3);
			exm_s4  <= exm_s3;
			eym_s4  <= eym_s3;
			sdx_s4  <= sdx_s3;
			sdy_s4  <= sdy_s3;
			side_s4 <= side_s3;

			dot_s5  <= 49'(px_s4) + 49'(py_s4);
			len2_s5 <= DEN_W'(lx_s4) + DEN_W'(ly_s4);
			exm_s5  <= exm_s4;
			eym_s5  <= eym_s4;
			sdx_s5  <= sdx_s4;
			sdy_s5  <= sdy_s4;
			side_s5 <= side_s4;

			nx_s6   <= 63'(dotm_c) * 63'(exm_s5);
			ny_s6   <= 63'(dotm_c) * 63'(eym_s5);
			len2_s6 <= len2_s5;
			side_s6 <= side6_c;

			sd1_s[0] <= side_s6;
			sd2_s[0] <= side7_c;
			for (int k = 1; k < DIV_STEPS; k++) begin
				sd1_s[k] <= sd1_s[k-1];
				sd2_s[k] <= sd2_s[k-1];
			end

			n_s7[0] <= {58'(qxm) * 58'(sd1_s[DIV_STEPS-1].mb_m), 1'b0};
			n_s7[1] <= {58'(qym) * 58'(sd1_s[DIV_STEPS-1].mb_m), 1'b0};
			n_s7[2] <= {58'(qxm) * 58'(sd1_s[DIV_STEPS-1].ma_m), 1'b0};
			n_s7[3] <= {58'(qym) * 58'(sd1_s[DIV_STEPS-1].ma_m), 1'b0};
			side_s7 <= side7n_c;

			if (sd2_s[DIV_STEPS-1].stat != ST_OK) begin
				for (int i = 0; i < 4; i++) begin
					vout_q[i] <= vin_c[i];
				end
				stat_q <= sd2_s[DIV_STEPS-1].stat;
			end else begin
				for (int i = 0; i < 4; i++) begin
					vout_q[i] <= vout_c[i];
				end
				stat_q <= (sat_c != 4'b0000) ? ST_SAT : ST_OK;
			end
		end
	end

	assign result_valid = out_vld_q;
	assign new_vel_a_x  = vout_q[0];
	assign new_vel_a_y  = vout_q[1];
	assign new_vel_b_x  = vout_q[2];
	assign new_vel_b_y  = vout_q[3];
	assign status       = stat_q;

endmodule
